/* hw/rtl/ichm_pkg.sv */
package ichm_pkg;

    localparam int MAX_SITES   = 64;
    localparam int SITE_W      = 6;
    localparam int LEN_W       = 7;
    localparam int RANDOM_BITS = 16;
    localparam int FRAC_W      = 16;
    localparam int SUM_W       = 8;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_UPDATE  = 2'd1,
        OP_MEASURE = 2'd2
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_SIGN      = 2'd1,
        REG_LENGTH    = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_SUM
    } meas_state_t;

    typedef logic signed [SUM_W-1:0] sum_t;

    typedef struct packed {
        opcode_t            opcode;
        logic [SITE_W-1:0]  site;
        logic               spin_value;
        logic [FRAC_W-1:0]  random_fraction;
        logic [SITE_W-1:0]  distance;
    } item_t;

    typedef struct packed {
        logic flipped;
        sum_t magnetization_sum;
        sum_t energy_sum;
        sum_t correlation_sum;
    } result_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic wr;
        logic wr_val;
        logic shift;
        logic wrap;
    } cell_ctl_t;

endpackage

/* hw/rtl/ichm_cell.sv */
module ichm_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  ichm_pkg::cell_ctl_t ctl,
    input  logic                next_spin,
    input  logic                head_spin,
    output logic                spin
);

    logic spin_reg;
    logic spin_next;

    // write wins; on shift the last active cell closes the ring from cell 0
    always_comb
    begin
        priority if (ctl.wr)
        begin
            spin_next = ctl.wr_val;
        end
        else if (ctl.shift)
        begin
            spin_next = ctl.wrap ? head_spin : next_spin;
        end
        else
        begin
            spin_next = spin_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spin_reg <= 1'b0;
        end
        else
        begin
            spin_reg <= spin_next;
        end
    end

    assign spin = spin_reg;

endmodule

/* hw/rtl/ising_chain_metropolis.sv */
// Periodic 1-D Ising chain with Metropolis single-spin updates.
// Item channel (item_valid / item_stall / item): a transaction carries one
// opcode - load spin, Metropolis update at a site, or measure.
// Result channel (result_valid / result_stall / result): exactly one
// transaction per item, in item order.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
// ready; writes are meant to happen while the block is idle.
// Load, update and unknown opcodes: the result is in the output register in
// the cycle after acceptance, and a new item may follow in the next cycle,
// i.e. one item per clock while the result side does not stall.
// A measure walks the ring: it first reduces distance modulo the chain
// length (one subtract per cycle), then the cells rotate the ring one place
// per cycle past a single adder set. After a full turn of chain_length
// places the ring is back where it started.
// No item is taken during a measure.
// Reset puts every spin at -1 and the registers at their defaults.
// A stalled result holds the output register; one more item is accepted
// only once that result is taken, so nothing is lost or repeated.
module ising_chain_metropolis (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  ichm_pkg::item_t                   item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output ichm_pkg::result_t                 result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ichm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ichm_pkg::FRAC_W-1:0]       cfg_data
);

    localparam int N  = ichm_pkg::MAX_SITES;
    localparam int SW = ichm_pkg::SITE_W;
    localparam int LW = ichm_pkg::LEN_W;

    // configuration registers
    logic [ichm_pkg::FRAC_W-1:0] threshold_reg;
    logic                        sign_reg;
    logic [LW-1:0]               length_reg;

    // sequencer state
    ichm_pkg::meas_state_t state_reg, state_next;
    logic [LW-1:0]         dmod_reg, dmod_next;
    logic [LW-1:0]         cnt_reg, cnt_next;
    ichm_pkg::sum_t        mag_reg, mag_next;
    ichm_pkg::sum_t        en_reg, en_next;
    ichm_pkg::sum_t        cor_reg, cor_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    ichm_pkg::result_t     out_reg, out_next;

    logic                  accept;
    logic                  shift_en;
    logic                  wr_any;
    logic                  wr_val;

    logic [N-1:0]          spins;
    ichm_pkg::cell_ctl_t   ctl [N];

    logic [LW-1:0]         len;
    logic [LW-1:0]         len_m1;
    logic                  site_ok;
    logic [LW-1:0]         site_ext;
    logic [LW-1:0]         right_idx;
    logic [LW-1:0]         left_idx;
    logic                  s_site, s_right, s_left;
    logic                  unfavourable;
    logic                  flip;
    logic                  s_head, s_next, s_far;

    // --------------------------------------------------------------
    // configuration port
    // --------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '1;
            sign_reg      <= 1'b0;
            length_reg    <= LW'(N);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ichm_pkg::REG_THRESHOLD: threshold_reg <= cfg_data;
                ichm_pkg::REG_SIGN:      sign_reg      <= cfg_data[0];
                ichm_pkg::REG_LENGTH:    length_reg    <= cfg_data[LW-1:0];
                default:                 ;
            endcase
        end
    end

    // effective length, clamped to 2..MAX_SITES
    always_comb
    begin
        priority if (length_reg < LW'(2))
        begin
            len = LW'(2);
        end
        else if (length_reg > LW'(N))
        begin
            len = LW'(N);
        end
        else
        begin
            len = length_reg;
        end
    end
    assign len_m1 = len - LW'(1);

    // --------------------------------------------------------------
    // handshake
    // --------------------------------------------------------------
    assign item_stall = (state_reg != ichm_pkg::ST_IDLE) || (out_valid_reg && result_stall);
    assign accept     = item_valid && !item_stall;

    // --------------------------------------------------------------
    // single-site access for load and update
    // --------------------------------------------------------------
    assign site_ext  = {1'b0, item.site};
    assign site_ok   = site_ext < len;
    assign right_idx = (site_ext + LW'(1) < len) ? site_ext + LW'(1) : '0;
    assign left_idx  = (site_ext == '0) ? len_m1 : site_ext - LW'(1);

    assign s_site  = spins[item.site];
    assign s_right = spins[right_idx[SW-1:0]];
    assign s_left  = spins[left_idx[SW-1:0]];

    // s*(l+r) is +-2 only when both neighbours agree; sign of the product
    // is + when they agree with s. Ferro: +2 is unfavourable, reversed: -2.
    assign unfavourable = (s_right == s_left) && ((s_right == s_site) ^ sign_reg);
    assign flip = !unfavourable
               || (item.random_fraction[ichm_pkg::RANDOM_BITS-1:0] < threshold_reg);

    always_comb
    begin
        wr_any = 1'b0;
        wr_val = item.spin_value;
        if (accept && site_ok)
        begin
            unique case (item.opcode)
                ichm_pkg::OP_LOAD:
                begin
                    wr_any = 1'b1;
                    wr_val = item.spin_value;
                end
                ichm_pkg::OP_UPDATE:
                begin
                    wr_any = flip;
                    wr_val = ~s_site;
                end
                default:
                begin
                    wr_any = 1'b0;
                end
            endcase
        end
    end

    // --------------------------------------------------------------
    // the cell row
    // --------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            assign ctl[gi].wr     = wr_any && (item.site == SW'(gi));
            assign ctl[gi].wr_val = wr_val;
            assign ctl[gi].shift  = shift_en && (LW'(gi) < len);
            assign ctl[gi].wrap   = (len_m1[SW-1:0] == SW'(gi));

            ichm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl[gi]),
                .next_spin (spins[(gi + 1) % N]),
                .head_spin (spins[0]),
                .spin      (spins[gi])
            );
        end
    endgenerate

    // --------------------------------------------------------------
    // measure sequencer: the ring rotates past cell 0, so cell 0 is
    // always site i, cell 1 its right neighbour and cell d site i+d
    // --------------------------------------------------------------
    assign s_head = spins[0];
    assign s_next = spins[1];
    assign s_far  = spins[dmod_reg[SW-1:0]];

    always_comb
    begin
        state_next     = state_reg;
        dmod_next      = dmod_reg;
        cnt_next       = cnt_reg;
        mag_next       = mag_reg;
        en_next        = en_reg;
        cor_next       = cor_reg;
        shift_en       = 1'b0;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;

        unique case (state_reg)
            ichm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    out_next = '0;
                    if (item.opcode == ichm_pkg::OP_MEASURE)
                    begin
                        state_next = ichm_pkg::ST_MOD;
                        dmod_next  = {1'b0, item.distance};
                        cnt_next   = '0;
                        mag_next   = '0;
                        en_next    = '0;
                        cor_next   = '0;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_next.flipped = (item.opcode == ichm_pkg::OP_UPDATE)
                                           && site_ok && flip;
                    end
                end
            end
            ichm_pkg::ST_MOD:
            begin
                if (dmod_reg < len)
                begin
                    state_next = ichm_pkg::ST_SUM;
                end
                else
                begin
                    dmod_next = dmod_reg - len;
                end
            end
            ichm_pkg::ST_SUM:
            begin
                shift_en = 1'b1;
                cnt_next = cnt_reg + LW'(1);
                mag_next = mag_reg + (s_head ? 8'sd1 : -8'sd1);
                en_next  = en_reg + ((s_head == s_next) ? -8'sd1 : 8'sd1);
                cor_next = cor_reg + ((s_head == s_far) ? 8'sd1 : -8'sd1);
                if (cnt_reg == len_m1)
                begin
                    state_next                 = ichm_pkg::ST_IDLE;
                    out_valid_next             = 1'b1;
                    out_next.flipped           = 1'b0;
                    out_next.magnetization_sum = mag_next;
                    out_next.energy_sum        = en_next;
                    out_next.correlation_sum   = cor_next;
                end
            end
            default:
            begin
                state_next = ichm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ichm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dmod_reg <= dmod_next;
        cnt_reg  <= cnt_next;
        mag_reg  <= mag_next;
        en_reg   <= en_next;
        cor_reg  <= cor_next;
        out_reg  <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

/* sim/ising_chain_metropolis_test.sv */
module ising_chain_metropolis_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ichm_pkg::*;

    // opcode 3 has no member in the package; the block must treat it as a no-op
    localparam opcode_t OP_UNKNOWN = opcode_t'(2'd3);

    // ------------------------------------------------------------------
    // Scoreboard: a private spin ring and register copy, updated as each
    // item transaction is accepted, and a queue of the results that the
    // ring predicts, oldest first.
    // ------------------------------------------------------------------
    class ising_scoreboard;
        logic [MAX_SITES-1:0] ring;
        logic [FRAC_W-1:0]    threshold;
        logic                 reversed;
        logic [LEN_W-1:0]     length_reg;
        result_t              awaited[$];
        int                   errors;
        int                   n_load, n_update, n_flip, n_measure, n_noop, n_cfg, n_checked;

        function new();
            ring       = '0;
            threshold  = 16'hFFFF;
            reversed   = 1'b0;
            length_reg = 7'd64;
            errors     = 0;
        endfunction

        task report(string msg);
            $display("[%0t] ERROR %s", $time, msg);
            errors++;
        endtask

        function int pending();
            return awaited.size();
        endfunction

        // lengths below 2 act as 2, above the ring size as the ring size
        function int eff_len();
            int l;
            l = length_reg;
            if (l < 2) l = 2;
            if (l > MAX_SITES) l = MAX_SITES;
            return l;
        endfunction

        function int spin(int i);
            return ring[i] ? 1 : -1;
        endfunction

        function sum_t clamp(int v);
            if (v > 127) v = 127;
            if (v < -128) v = -128;
            return sum_t'(v);
        endfunction

        function void note_config(cfg_reg_t idx, logic [FRAC_W-1:0] v);
            n_cfg++;
            case (idx)
                REG_THRESHOLD: threshold  = v;
                REG_SIGN:      reversed   = v[0];
                REG_LENGTH:    length_reg = v[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_item(item_t x);
            result_t     r;
            int          len, right, left, prod, unfav, mag, en, cor, d;
            int unsigned rnd;
            r   = '0;
            len = eff_len();
            rnd = x.random_fraction & ((32'd1 << RANDOM_BITS) - 1);
            case (x.opcode)
                OP_LOAD:
                begin
                    n_load++;
                    if (x.site < len) ring[x.site] = x.spin_value;
                    else n_noop++;
                end
                OP_UPDATE:
                begin
                    n_update++;
                    if (x.site < len)
                    begin
                        right = (x.site + 1 < len) ? x.site + 1 : 0;
                        left  = (x.site == 0) ? len - 1 : x.site - 1;
                        prod  = spin(x.site) * (spin(right) + spin(left));
                        unfav = reversed ? -2 : 2;
                        if (prod != unfav || rnd < threshold)
                        begin
                            ring[x.site] = ~ring[x.site];
                            r.flipped    = 1'b1;
                            n_flip++;
                        end
                    end
                    else
                        n_noop++;
                end
                OP_MEASURE:
                begin
                    n_measure++;
                    mag = 0;
                    en  = 0;
                    cor = 0;
                    d   = x.distance % len;
                    for (int i = 0; i < len; i++)
                    begin
                        right = (i + 1 < len) ? i + 1 : 0;
                        mag  += spin(i);
                        en   -= spin(i) * spin(right);
                        cor  += spin(i) * spin((i + d) % len);
                    end
                    r.magnetization_sum = clamp(mag);
                    r.energy_sum        = clamp(en);
                    r.correlation_sum   = clamp(cor);
                end
                default: n_noop++;
            endcase
            awaited.push_back(r);
        endfunction

        task check_result(result_t got);
            result_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("result transaction with nothing outstanding: %h", got));
                return;
            end
            want = awaited.pop_front();
            n_checked++;
            if (got.flipped !== want.flipped)
                report($sformatf("flipped %b, expected %b", got.flipped, want.flipped));
            if (got.magnetization_sum !== want.magnetization_sum)
                report($sformatf("magnetization_sum %0d, expected %0d",
                                 got.magnetization_sum, want.magnetization_sum));
            if (got.energy_sum !== want.energy_sum)
                report($sformatf("energy_sum %0d, expected %0d",
                                 got.energy_sum, want.energy_sum));
            if (got.correlation_sum !== want.correlation_sum)
                report($sformatf("correlation_sum %0d, expected %0d",
                                 got.correlation_sum, want.correlation_sum));
        endtask
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    logic                 item_stall;
    item_t                item         = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    result_t              result;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [FRAC_W-1:0]    cfg_data     = '0;

    ising_scoreboard sb;

    int   send_idle_pct  = 0;   // chance per cycle that the item side idles
    int   recv_stall_pct = 0;   // chance per cycle that the result side stalls
    bit   holding        = 1'b0;
    event hold_off_ev;

    always #6 clk = ~clk;

    ising_chain_metropolis dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Result side: random stalls, overridden by the long hold-off.
    // Driven on the falling edge so the block sees a settled value.
    always @(negedge clk)
        result_stall <= holding || ($urandom_range(99) < recv_stall_pct);

    // Long hold-off, timed in cycles by this process alone.  The item side
    // keeps offering transactions meanwhile, so the block backs up.
    always
    begin
        @(hold_off_ev);
        holding = 1'b1;
        repeat (200) @(posedge clk);
        holding = 1'b0;
    end

    // Monitor: a result transaction completes on a rising edge with
    // valid high and stall low.
    always @(posedge clk)
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);

    // Watchdog - far beyond the slowest legal run (every item a full
    // measure plus the receiver's worst stalls).
    initial
    begin
        #5_000_000;
        $display("[%0t] ERROR timeout, %0d results outstanding", $time, sb.pending());
        $display("FAIL ising_chain_metropolis");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one item transaction; valid stays high afterwards so that a
    // following item can go back to back.
    task automatic send_item(item_t x);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= x;
        do @(posedge clk); while (item_stall);
        sb.note_item(x);
    endtask

    // Stop offering items and wait until every predicted result is back.
    // Every item yields a result, so a short settle time is plenty.
    task automatic drain();
        @(negedge clk);
        item_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [FRAC_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.note_config(idx, v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // All three registers; junk in the unused upper bits of sign and length.
    task automatic configure(logic [FRAC_W-1:0] thr, logic sgn, int len);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_SIGN, (16'($urandom) & 16'hFFFE) | 16'(sgn));
        write_reg(REG_LENGTH, (16'($urandom) & 16'hFF80) | 16'(len));
    endtask

    function automatic item_t mk(opcode_t op, int s, bit sp, int r, int d);
        item_t x;
        x.opcode          = op;
        x.site            = SITE_W'(s);
        x.spin_value      = sp;
        x.random_fraction = FRAC_W'(r);
        x.distance        = SITE_W'(d);
        return x;
    endfunction

    // Fractions cluster round the threshold, so the strict compare is hit
    // from both sides, with the extremes and plain uniform values mixed in.
    function automatic logic [FRAC_W-1:0] pick_fraction();
        case ($urandom_range(9))
            0:       return sb.threshold;
            1:       return sb.threshold - 1'b1;
            2:       return sb.threshold + 1'b1;
            3:       return '0;
            4:       return '1;
            default: return FRAC_W'($urandom);
        endcase
    endfunction

    // Mostly well-formed traffic: updates on live sites with the odd load
    // and a sparse measure; a tenth is noise (dead sites, unknown opcode).
    function automatic item_t rand_item();
        item_t       x;
        int unsigned roll;
        int          len;
        roll              = $urandom_range(99);
        len               = sb.eff_len();
        x.opcode          = OP_UPDATE;
        x.site            = SITE_W'($urandom_range(len - 1));
        x.spin_value      = 1'($urandom);
        x.random_fraction = pick_fraction();
        x.distance        = SITE_W'($urandom);
        if (roll < 12)
            x.opcode = OP_LOAD;
        else if (roll < 82)
            x.opcode = OP_UPDATE;
        else if (roll < 90)
            x.opcode = OP_MEASURE;
        else if (roll < 95)
        begin
            x.opcode = $urandom_range(1) ? OP_LOAD : OP_UPDATE;
            if (len < MAX_SITES)
                x.site = SITE_W'($urandom_range(MAX_SITES - 1, len));
        end
        else
        begin
            x.opcode          = OP_UNKNOWN;
            x.site            = SITE_W'($urandom);
            x.random_fraction = FRAC_W'($urandom);
        end
        return x;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        logic [FRAC_W-1:0] thr;
        logic              sgn;
        int                len;

        sb = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, on reset defaults: all spins down, threshold at its
        // top, ferromagnetic sign, full ring.
        send_item(mk(OP_MEASURE, 0, 0, 0, 0));           // all -1 ring
        send_item(mk(OP_LOAD, 0, 1, 0, 0));
        send_item(mk(OP_LOAD, 63, 1, 0, 0));              // top site
        send_item(mk(OP_UPDATE, 0, 0, 16'hFFFF, 0));      // neutral: always flips
        send_item(mk(OP_UPDATE, 63, 0, 16'hFFFF, 0));     // favourable: always flips
        send_item(mk(OP_UPDATE, 10, 0, 16'hFFFF, 0));     // unfavourable, fraction = limit
        send_item(mk(OP_UPDATE, 10, 0, 0, 0));            // unfavourable, fraction below
        send_item(mk(OP_UNKNOWN, 63, 1, 16'hFFFF, 63));   // unknown opcode, all ones
        send_item(mk(OP_LOAD, 5, 0, 16'hFFFF, 63));
        send_item(mk(OP_MEASURE, 63, 1, 16'hFFFF, 63));
        drain();

        // Short ring, reversed sign, zero threshold: dead sites ignored
        configure(16'h0000, 1'b1, 5);
        send_item(mk(OP_UPDATE, 40, 0, 0, 0));            // site beyond ring
        send_item(mk(OP_LOAD, 63, 1, 0, 0));              // site beyond ring
        send_item(mk(OP_LOAD, 2, 1, 0, 0));
        send_item(mk(OP_UPDATE, 4, 0, 0, 0));
        send_item(mk(OP_UPDATE, 2, 0, 0, 0));
        send_item(mk(OP_UPDATE, 0, 0, 16'hFFFF, 0));
        send_item(mk(OP_MEASURE, 0, 0, 0, 63));           // distance wraps modulo 5
        drain();

        // Length 0 acts as 2
        configure(16'h8000, 1'b0, 0);
        send_item(mk(OP_LOAD, 1, 1, 0, 0));
        send_item(mk(OP_UPDATE, 2, 0, 0, 0));             // beyond the two-site ring
        send_item(mk(OP_UPDATE, 0, 0, 16'h7FFF, 0));
        send_item(mk(OP_MEASURE, 0, 0, 0, 1));
        drain();

        // Length 127 acts as the full ring
        configure(16'hFFFF, 1'b1, 127);
        send_item(mk(OP_MEASURE, 0, 0, 0, 32));
        drain();

        // Random part in nine segments, each with its own register setting.
        // Segments 0-2: sender rarely idles, receiver stalls often;
        // 3-5 the reverse; 6-8 neither side idles.
        for (int seg = 0; seg < 9; seg++)
        begin
            case (seg)
                0:       begin thr = 16'h4000;        sgn = 1'b0; len = 64;  end
                1:       begin thr = 16'h0000;        sgn = 1'b1; len = 2;   end
                2:       begin thr = 16'hFFFF;        sgn = 1'b0; len = 17;  end
                3:       begin thr = FRAC_W'($urandom); sgn = 1'b1; len = 127; end
                4:       begin thr = 16'h8000;        sgn = 1'b0; len = 5;   end
                5:       begin thr = 16'h0001;        sgn = 1'b1; len = 1;   end
                6:       begin thr = FRAC_W'($urandom); sgn = 1'b0; len = 64;  end
                7:       begin thr = 16'hFFFE;        sgn = 1'b1; len = 33;  end
                default: begin thr = FRAC_W'($urandom); sgn = 1'b0; len = 100; end
            endcase
            configure(thr, sgn, len);

            if (seg < 3)
            begin
                send_idle_pct  = 6;
                recv_stall_pct = 47;
            end
            else if (seg < 6)
            begin
                send_idle_pct  = 47;
                recv_stall_pct = 6;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end

            for (int n = 0; n < 50; n++)
            begin
                if (seg == 6 && n == 5)
                    -> hold_off_ev;     // receiver backs off, items keep coming
                if (seg == 4 && n == 25)
                    drain();            // sender waits for a fully empty pipe
                send_item(rand_item());
            end
            drain();
        end

        // Extra settle time covers a late or spurious result after a measure
        repeat (120) @(posedge clk);

        $display("Covered %0d loads, %0d updates (%0d flipped), %0d measures, %0d no-ops",
                 sb.n_load, sb.n_update, sb.n_flip, sb.n_measure, sb.n_noop);
        $display("over %0d register writes; %0d results checked, %0d mismatches",
                 sb.n_cfg, sb.n_checked, sb.errors);
        if (sb.errors == 0)
            $display("PASS ising_chain_metropolis");
        else
            $display("FAIL ising_chain_metropolis");
        $finish;
    end

endmodule
